/* hdl/bsfd_pkg.sv */
// shared types and constants of the byte stuffing frame decoder
package bsfd_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h41;
  localparam logic [7:0] ESC_BYTE  = 8'h42;
  localparam logic [7:0] ESC_FLAG  = 8'h43;
  localparam logic [7:0] ESC_ESC   = 8'h44;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  localparam int unsigned MAX_LEN_W = 15;
  localparam int unsigned COUNT_W   = 16;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 15'd512;

  typedef enum logic [2:0] {
    MODE_HUNT  = 3'b001,
    MODE_FRAME = 3'b010,
    MODE_ESC   = 3'b100
  } mode_t;

  // one queued command: an optional leading literal escape byte, then the main result
  typedef struct packed {
    logic               lit_b;
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] frame_length;
  } cmd_t;

endpackage

/* hdl/bsfd_byte_if.sv */
// channel interfaces: raw received bytes and decoded results
interface bsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface bsfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;
  logic        last;
  modport source(output valid, output kind, output data_byte, output frame_length,
                 output last, input ready);
  modport sink(input valid, input kind, input data_byte, input frame_length,
               input last, output ready);
endinterface

/* hdl/bsfd_front.sv */
// front end: accepts raw bytes, tracks framing state, emits commands
module bsfd_front import bsfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bsfd_byte_if.sink            byte_chan,
  input  logic [MAX_LEN_W-1:0] max_len,
  input  logic                 queue_full,
  output logic                 push,
  output cmd_t                 cmd
);

  mode_t              mode, mode_next;
  logic [COUNT_W-1:0] raw_count, raw_count_next;
  logic [COUNT_W-1:0] decoded_count, decoded_count_next;
  logic [COUNT_W-1:0] raw_inc;
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] dec_base;
  logic               lit;
  logic               accept;
  logic               emit;
  logic [7:0]         b;

  assign byte_chan.ready = !queue_full;
  assign accept = byte_chan.valid && !queue_full;
  assign push   = accept && emit;
  assign b      = byte_chan.rx_byte;
  assign raw_inc = raw_count + COUNT_W'(1);
  assign limit   = {max_len, 1'b0};
  assign lit     = (mode == MODE_ESC);
  assign dec_base = decoded_count + COUNT_W'(lit);

  always_comb begin
    mode_next          = mode;
    raw_count_next     = raw_count;
    decoded_count_next = decoded_count;
    emit               = 1'b0;
    cmd                = '0;
    case (mode)
      MODE_FRAME, MODE_ESC: begin
        raw_count_next = raw_inc;
        if (raw_inc > limit) begin
          // limit test comes first, a pending escape is dropped
          emit      = 1'b1;
          cmd.kind  = KIND_OVF;
          mode_next = MODE_HUNT;
        end else if (lit && b == ESC_FLAG) begin
          emit               = 1'b1;
          cmd.kind           = KIND_DATA;
          cmd.data_byte      = FLAG_BYTE;
          decoded_count_next = decoded_count + COUNT_W'(1);
          mode_next          = MODE_FRAME;
        end else if (lit && b == ESC_ESC) begin
          emit               = 1'b1;
          cmd.kind           = KIND_DATA;
          cmd.data_byte      = ESC_BYTE;
          decoded_count_next = decoded_count + COUNT_W'(1);
          mode_next          = MODE_FRAME;
        end else if (b == FLAG_BYTE) begin
          emit               = 1'b1;
          cmd.lit_b          = lit;
          cmd.kind           = KIND_END;
          cmd.frame_length   = dec_base;
          decoded_count_next = dec_base;
          mode_next          = MODE_HUNT;
        end else if (b == ESC_BYTE) begin
          // a stale escape becomes a literal, the new one stays pending
          emit               = lit;
          cmd.kind           = KIND_DATA;
          cmd.data_byte      = ESC_BYTE;
          decoded_count_next = dec_base;
          mode_next          = MODE_ESC;
        end else begin
          emit               = 1'b1;
          cmd.lit_b          = lit;
          cmd.kind           = KIND_DATA;
          cmd.data_byte      = b;
          decoded_count_next = dec_base + COUNT_W'(1);
          mode_next          = MODE_FRAME;
        end
      end
      default: begin
        mode_next = MODE_HUNT;
        if (b == FLAG_BYTE) begin
          mode_next          = MODE_FRAME;
          raw_count_next     = '0;
          decoded_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_HUNT;
      raw_count     <= '0;
      decoded_count <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      raw_count     <= raw_count_next;
      decoded_count <= decoded_count_next;
    end
  end

endmodule

/* hdl/bsfd_queue.sv */
// command queue between front and back end
module bsfd_queue import bsfd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/bsfd_back.sv */
// back end: expands commands into result items through an output register
module bsfd_back import bsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  bsfd_result_if.source result_chan
);

  logic out_valid;
  logic b_sent;
  logic load;
  logic lead;

  assign load = head_valid && (!out_valid || result_chan.ready);
  assign lead = head.lit_b && !b_sent;
  assign pop  = load && !lead;
  assign result_chan.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      b_sent    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        b_sent    <= lead;
      end else if (result_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (lead) begin
        result_chan.kind         <= KIND_DATA;
        result_chan.data_byte    <= ESC_BYTE;
        result_chan.frame_length <= '0;
        result_chan.last         <= 1'b0;
      end else begin
        result_chan.kind         <= head.kind;
        result_chan.data_byte    <= head.data_byte;
        result_chan.frame_length <= head.frame_length;
        result_chan.last         <= 1'b1;
      end
    end
  end

endmodule

/* hdl/byte_stuffing_frame_decoder.sv */
// top level of the byte stuffing frame decoder
// byte_chan takes one raw received byte per request (valid/ready). the block
// hunts for the flag byte, then unstuffs the payload until the closing flag.
// result_chan gives one result per request: kind (data, end of frame,
// overflow), data_byte, frame_length and last, which marks the final result
// of one input byte. an input byte causes zero, one or two results.
// each result passes the command queue, written when its byte is accepted, and
// then the output register, which loads when empty or when its result is taken.
// throughput: one byte per cycle while each byte gives at most one result;
// a byte that gives two results holds the output register for both in turn,
// and the command queue (QUEUE_DEPTH entries) absorbs such bursts.
// when the receiver stalls, results wait in the output register and the queue;
// byte_chan keeps taking bytes until the queue is full.
// configuration: max_len at byte address 0 over the apb port, reset 512. the user
// must see that it is written only while the block is idle; the block itself has
// no check for this. the raw frame limit is twice max_len.
// reset (rst, synchronous) returns to hunting, clears counters and the queue.
module byte_stuffing_frame_decoder import bsfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  bsfd_byte_if.sink     byte_chan,
  bsfd_result_if.source result_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [MAX_LEN_W-1:0] max_len;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic queue_full;

  // queue to back
  logic head_valid;
  cmd_t head;
  logic pop;

  // apb register: only word address 0 holds max_len
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - MAX_LEN_W){1'b0}}, max_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_len <= pwdata[MAX_LEN_W-1:0];
    end
  end

  // framing state and classification of each byte
  bsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_chan  (byte_chan),
    .max_len    (max_len),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // decouples byte intake from result delivery
  bsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // result generation, one result per cycle while the queue holds commands and the receiver is ready
  bsfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .result_chan (result_chan)
  );

endmodule

/* tb/byte_stuffing_frame_decoder_test.sv */
// self-checking testbench of the byte stuffing frame decoder: directed and random frames
module byte_stuffing_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bsfd_pkg::*;

  // register map and run limits
  localparam logic [2:0] MAX_LEN_ADDR = 3'd0;
  localparam int         PHASE_ITEMS  = 225;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         LIMIT_CYCLES = 200000;

  // one decoded result as seen on result_chan
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] frame_length;
    logic               last;
  } result_t;

  // tracks the deframer state and holds the results still owed by the block
  class frame_scoreboard;
    mode_t                mode;
    logic [COUNT_W-1:0]   raw_count;
    logic [COUNT_W-1:0]   decoded_count;
    logic [MAX_LEN_W-1:0] max_len;
    result_t              owed_results[$];
    result_t              fresh[$];
    int                   errors;
    int                   checked;

    function new();
      mode          = MODE_HUNT;
      raw_count     = '0;
      decoded_count = '0;
      max_len       = MAX_LEN_RESET;
      errors        = 0;
      checked       = 0;
    endfunction

    function void set_max_len(logic [MAX_LEN_W-1:0] v);
      max_len = v;
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] data, logic [COUNT_W-1:0] len);
      result_t r;
      r.kind         = kind;
      r.data_byte    = data;
      r.frame_length = len;
      r.last         = 1'b0;
      fresh.push_back(r);
      if (kind == KIND_DATA) decoded_count++;
    endfunction

    // a byte inside a frame with no escape pending
    function void plain_byte(logic [7:0] b);
      if (b == FLAG_BYTE) begin
        add_result(KIND_END, 8'd0, decoded_count);
        mode = MODE_HUNT;
      end else if (b == ESC_BYTE) begin
        mode = MODE_ESC;
      end else begin
        mode = MODE_FRAME;
        add_result(KIND_DATA, b, '0);
      end
    endfunction

    // returns 1 when the byte was taken by the framer rather than ignored
    function bit note_byte(logic [7:0] b);
      result_t r;
      fresh.delete();
      if (mode != MODE_FRAME && mode != MODE_ESC) begin
        mode = MODE_HUNT;
        if (b == FLAG_BYTE) begin
          mode          = MODE_FRAME;
          raw_count     = '0;
          decoded_count = '0;
          return 1'b1;
        end
        return 1'b0;
      end
      raw_count++;
      // limit test comes first, a pending escape is dropped
      if ({1'b0, raw_count} > {1'b0, max_len, 1'b0}) begin
        add_result(KIND_OVF, 8'd0, '0);
        mode = MODE_HUNT;
      end else if (mode == MODE_ESC) begin
        if (b == ESC_FLAG) begin
          mode = MODE_FRAME;
          add_result(KIND_DATA, FLAG_BYTE, '0);
        end else if (b == ESC_ESC) begin
          mode = MODE_FRAME;
          add_result(KIND_DATA, ESC_BYTE, '0);
        end else begin
          add_result(KIND_DATA, ESC_BYTE, '0);
          plain_byte(b);
        end
      end else begin
        plain_byte(b);
      end
      if (fresh.size() > 0) begin
        r      = fresh.pop_back();
        r.last = 1'b1;
        fresh.push_back(r);
      end
      foreach (fresh[i]) owed_results.push_back(fresh[i]);
      return 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                 $time, got.kind, got.data_byte);
        $display("%0t: unexpected result, actual length %0d last %0d",
                 $time, got.frame_length, got.last);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: result %0d kind expected %0d, actual %0d",
                 $time, checked, want.kind, got.kind);
        errors++;
      end
      if (got.data_byte != want.data_byte) begin
        $display("%0t: result %0d data_byte expected %0h, actual %0h",
                 $time, checked, want.data_byte, got.data_byte);
        errors++;
      end
      if (got.frame_length != want.frame_length) begin
        $display("%0t: result %0d frame_length expected %0d, actual %0d",
                 $time, checked, want.frame_length, got.frame_length);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: result %0d last expected %0d, actual %0d",
                 $time, checked, want.last, got.last);
        errors++;
      end
      checked++;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bsfd_byte_if   byte_chan();
  bsfd_result_if result_chan();

  frame_scoreboard sb = new();

  // idle_on enables random gaps on both sides; a toggle of hold_toggle asks the
  // receiver for one long hold-off
  bit idle_on     = 1'b1;
  bit hold_toggle = 1'b0;
  int sent_items  = 0;

  always #4 clk = ~clk;

  byte_stuffing_frame_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_chan  (byte_chan),
    .result_chan(result_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // offer one raw byte and hold it until the request is taken
  task automatic send_byte(input logic [7:0] b);
    // random gaps before the request, valid low meanwhile
    while (idle_on && $urandom_range(0, 99) < 6) begin
      byte_chan.valid <= 1'b0;
      @(posedge clk);
    end
    byte_chan.valid   <= 1'b1;
    byte_chan.rx_byte <= b;
    @(posedge clk);
    while (!byte_chan.ready) @(posedge clk);
    // accepted at this edge: update the predicted state
    void'(sb.note_byte(b));
    sent_items++;
  endtask

  // stop offering and wait until every owed result has come out
  task automatic wait_drained();
    byte_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a trailing byte with no result may still be in the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write of max_len: setup then access, only with the block idle
  task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= {{(32 - MAX_LEN_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_max_len(v);
  endtask

  // one mostly well-formed frame with random content and the odd broken escape
  task automatic send_random_frame();
    int          len;
    int          r;
    logic [7:0]  p;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
    send_byte(FLAG_BYTE);
    repeat (len) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        // escape followed by an arbitrary byte
        send_byte(ESC_BYTE);
        send_byte(8'($urandom_range(0, 255)));
      end else if (r == 1) begin
        // raw byte left unstuffed, may close the frame early
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // payload byte, biased toward the flag and escape codes
        p = (r < 6) ? 8'(FLAG_BYTE + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        if (p == FLAG_BYTE) begin
          send_byte(ESC_BYTE);
          send_byte(ESC_FLAG);
        end else if (p == ESC_BYTE) begin
          send_byte(ESC_BYTE);
          send_byte(ESC_ESC);
        end else begin
          send_byte(p);
        end
      end
    end
    // most frames close, a few are left open for the next flag to close
    if ($urandom_range(0, 9) != 0) send_byte(FLAG_BYTE);
    // noise between frames, ignored while hunting unless it holds a flag
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result side: takes each result request and checks it, with random stalls
  // and one long hold-off counted here
  initial begin : result_sink
    int      hold_left;
    bit      seen_toggle;
    result_t got;
    hold_left   = 0;
    seen_toggle = 1'b0;
    result_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_chan.valid && result_chan.ready) begin
        got.kind         = result_chan.kind;
        got.data_byte    = result_chan.data_byte;
        got.frame_length = result_chan.frame_length;
        got.last         = result_chan.last;
        sb.check_result(got);
      end
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_chan.ready <= 1'b0;
      end else begin
        result_chan.ready <= !(idle_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  // watchdog: a run that hangs ends here
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned settings [7];
    int          base_items;
    bit          paused;
    logic [MAX_LEN_W-1:0] setting;

    settings = '{512, 32767, 3, 1, 0, 200, 0};
    byte_chan.valid   <= 1'b0;
    byte_chan.rx_byte <= 8'd0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset max_len
    send_byte(8'h00);               // hunting ignores anything but the flag
    send_byte(8'hFF);
    send_byte(FLAG_BYTE);           // opens a frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESC_BYTE);            // stuffed flag
    send_byte(ESC_FLAG);
    send_byte(ESC_BYTE);            // stuffed escape
    send_byte(ESC_ESC);
    send_byte(ESC_BYTE);            // escape then other byte: two results
    send_byte(8'h7E);
    send_byte(ESC_BYTE);            // escape then escape stays escaped
    send_byte(ESC_BYTE);
    send_byte(ESC_ESC);
    send_byte(ESC_BYTE);            // escape then flag: literal then end of frame
    send_byte(FLAG_BYTE);
    send_byte(FLAG_BYTE);           // closing flag did not reopen, so this opens
    send_byte(FLAG_BYTE);           // empty frame

    // smallest legal limit: overflow beats the closing flag
    write_max_len(15'd1);
    send_byte(FLAG_BYTE);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(FLAG_BYTE);
    // overflow cuts a pending escape
    send_byte(FLAG_BYTE);
    send_byte(ESC_BYTE);
    send_byte(ESC_BYTE);
    send_byte(8'h55);

    // out-of-range zero: the first raw byte overflows
    write_max_len(15'd0);
    send_byte(FLAG_BYTE);
    send_byte(8'h5A);

    // random part, one phase per max_len setting
    for (int ph = 0; ph < 7; ph++) begin
      setting = (ph == 6) ? MAX_LEN_W'($urandom_range(4, 40)) : MAX_LEN_W'(settings[ph]);
      write_max_len(setting);
      // phase 1 runs with no gaps on either side
      idle_on = (ph != 1);
      // phase 0 starts with a long receiver hold-off while bytes keep coming
      if (ph == 0) hold_toggle <= ~hold_toggle;
      base_items = sent_items;
      paused     = 1'b0;
      while (sent_items - base_items < PHASE_ITEMS) begin
        send_random_frame();
        // one sender pause mid-phase until every result is out
        if (ph == 2 && !paused && sent_items - base_items > PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
